// ===== design/rbd_pkg.sv =====
// types and constants shared by the run-length byte decoder
package rbd_pkg;

  // one compressed byte as held in the input register
  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } in_item_t;

  // one decoded result
  typedef struct packed {
    logic [7:0] out_value;
    logic [7:0] repeat_count;
    logic       frame_end;
    logic       status;
  } out_item_t;

  // decoder phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_REPEAT  = 3'b010,
    PH_LITERAL = 3'b100
  } phase_t;

  // handshake between the decode stage and its neighbors
  typedef struct packed {
    logic take;  // input register is consumed this cycle
    logic emit;  // a result is loaded into the output register
  } dec_ctl_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OVERRUN = 1'b1;

  localparam logic [7:0] HDR_NOP       = 8'h00;
  localparam logic [7:0] HDR_LIT_FIRST = 8'h80;

endpackage

// ===== design/rbd_if.sv =====
// channel interfaces: compressed input, decoded output, configuration write
interface rbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_start;

  modport source (output valid, output in_byte, output frame_start, input ready);
  modport sink (input valid, input in_byte, input frame_start, output ready);
endinterface

interface rbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic [7:0] repeat_count;
  logic       frame_end;
  logic       status;

  modport source (
    output valid, output out_value, output repeat_count, output frame_end,
    output status, input ready
  );
  modport sink (
    input valid, input out_value, input repeat_count, input frame_end,
    input status, output ready
  );
endinterface

interface rbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;

  modport source (output valid, output frame_length, input ready);
  modport sink (input valid, input frame_length, output ready);
endinterface

// ===== design/rbd_in_stage.sv =====
// input register: holds one compressed byte until the decode stage takes it
module rbd_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rbd_pkg::in_item_t in_item,
  input  logic             take,
  output logic             held_valid,
  output rbd_pkg::in_item_t held_item
);
  import rbd_pkg::*;

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== design/rbd_decode.sv =====
// decode stage: run state, frame byte budget and result formation
module rbd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              held_valid,
  input  rbd_pkg::in_item_t held_item,
  input  logic [15:0]       frame_length,
  input  logic              slot_free,
  output rbd_pkg::dec_ctl_t ctl,
  output rbd_pkg::out_item_t result
);
  import rbd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  run_left, run_left_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        frame_done, frame_done_next;

  phase_t      eff_phase;
  logic [7:0]  eff_run;
  logic [15:0] eff_left;
  logic        eff_done;
  logic [7:0]  count;
  logic [15:0] left_after;
  logic        has_result;

  always_comb begin
    // a frame start reloads the budget before the byte is decoded
    eff_phase = held_item.frame_start ? PH_HEADER : phase;
    eff_run   = held_item.frame_start ? 8'd0 : run_left;
    eff_left  = held_item.frame_start ? frame_length : bytes_left;
    eff_done  = held_item.frame_start ? (frame_length == 16'd0) : frame_done;

    phase_next      = eff_phase;
    run_left_next   = eff_run;
    bytes_left_next = eff_left;
    frame_done_next = eff_done;

    count      = 8'd0;
    left_after = eff_left;
    has_result = 1'b1;

    result.out_value    = held_item.in_byte;
    result.repeat_count = 8'd0;
    result.frame_end    = 1'b0;
    result.status       = STATUS_OVERRUN;

    if (!eff_done) begin
      case (eff_phase)
        PH_REPEAT: begin
          count = ({8'd0, eff_run} > eff_left) ? eff_left[7:0] : eff_run;
          left_after    = eff_left - {8'd0, count};
          phase_next    = PH_HEADER;
          run_left_next = 8'd0;
        end
        PH_LITERAL: begin
          count         = 8'd1;
          left_after    = eff_left - 16'd1;
          run_left_next = eff_run - 8'd1;
          phase_next    = (eff_run == 8'd1) ? PH_HEADER : PH_LITERAL;
        end
        default: begin
          // header byte, no result
          has_result = 1'b0;
          if (held_item.in_byte == HDR_NOP) begin
            phase_next    = PH_HEADER;
            run_left_next = 8'd0;
          end else if (held_item.in_byte < HDR_LIT_FIRST) begin
            phase_next    = PH_REPEAT;
            run_left_next = held_item.in_byte;
          end else begin
            phase_next    = PH_LITERAL;
            run_left_next = 8'd0 - held_item.in_byte;
          end
        end
      endcase

      if (has_result) begin
        bytes_left_next = left_after;
        if (left_after == 16'd0) begin
          frame_done_next = 1'b1;
          phase_next      = PH_HEADER;
          run_left_next   = 8'd0;
        end
        result.repeat_count = count;
        result.frame_end    = (left_after == 16'd0);
        result.status       = STATUS_OK;
      end
    end

    ctl.take = held_valid && (!has_result || slot_free);
    ctl.emit = ctl.take && has_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      run_left   <= 8'd0;
      bytes_left <= 16'd0;
      frame_done <= 1'b1;
    end else if (ctl.take) begin
      phase      <= phase_next;
      run_left   <= run_left_next;
      bytes_left <= bytes_left_next;
      frame_done <= frame_done_next;
    end
  end

  // a result never leaves without its byte being consumed
  assert property (@(posedge clk) disable iff (rst) ctl.emit |-> ctl.take)
    else $error("result emitted without taking the held byte");

  // an open frame always owes bytes
  assert property (@(posedge clk) disable iff (rst) !frame_done |-> bytes_left != 16'd0)
    else $error("open frame with zero bytes left");

  // waiting for a header means no run is pending
  assert property (@(posedge clk) disable iff (rst) phase == PH_HEADER |-> run_left == 8'd0)
    else $error("run count left over in header phase");

  // a frame-end result closes the frame
  assert property (@(posedge clk) disable iff (rst)
    ctl.emit && result.frame_end |=> frame_done)
    else $error("frame end reported but frame still open");

endmodule

// ===== design/rbd_out_stage.sv =====
// output register: holds one result until the downstream side takes it
module rbd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  rbd_pkg::out_item_t load_item,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_ready,
  output rbd_pkg::out_item_t out_item
);
  import rbd_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

// ===== design/rle_byte_decoder.sv =====
// a data byte passes the input register, and its result is then loaded into the output register
// throughput: one compressed byte per cycle unless an output stall holds it, set by the
//   single decode stage between the input register and the output register
// header bytes in an open frame give no result; an output stall holds the pipeline only when
//   the held byte would give a result
// reset (synchronous, rst high): no frame open, frame_length 0, registers empty
module rle_byte_decoder (
  input logic      clk,
  input logic      rst,
  rbd_in_if.sink   comp,
  rbd_out_if.source decomp,
  rbd_cfg_if.sink  cfg
);
  import rbd_pkg::*;

  // configuration: frame length, always writable
  logic [15:0] frame_length;

  // input register contents
  in_item_t  comp_item;
  in_item_t  held_item;
  logic      held_valid;

  // decode stage handshake and result
  dec_ctl_t  ctl;
  out_item_t result;
  out_item_t out_item;
  logic      slot_free;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= 16'd0;
    end else if (cfg.valid && cfg.ready) begin
      frame_length <= cfg.frame_length;
    end
  end

  // pack the incoming transfer
  assign comp_item.in_byte     = comp.in_byte;
  assign comp_item.frame_start = comp.frame_start;

  rbd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (comp.valid),
    .in_ready   (comp.ready),
    .in_item    (comp_item),
    .take       (ctl.take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // run decoding and frame accounting
  rbd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .held_item    (held_item),
    .frame_length (frame_length),
    .slot_free    (slot_free),
    .ctl          (ctl),
    .result       (result)
  );

  // result register, refilled in the same cycle it drains
  rbd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (ctl.emit),
    .load_item (result),
    .slot_free (slot_free),
    .out_valid (decomp.valid),
    .out_ready (decomp.ready),
    .out_item  (out_item)
  );

  assign decomp.out_value    = out_item.out_value;
  assign decomp.repeat_count = out_item.repeat_count;
  assign decomp.frame_end    = out_item.frame_end;
  assign decomp.status       = out_item.status;

endmodule

// ===== dv/rle_byte_decoder_tb.sv =====
`timescale 1ns / 100ps
// testbench for rle_byte_decoder: directed and random compressed frames checked by a predictor
module rle_byte_decoder_tb;
  import rbd_pkg::*;

  // generous cycle budget, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  // minimum compressed bytes queued per frame_length setting in the random part
  localparam int unsigned PHASE_BYTES   = 170;
  // a random frame starts no new run past this many compressed bytes, keeps long frames cheap
  localparam int unsigned FRAME_BUDGET  = 60;
  // quiet cycles after the last result, since a trailing header byte gives no result at all
  localparam int unsigned SETTLE_CYCLES = 4;
  // mismatch lines printed before going quiet (all of them are counted)
  localparam int unsigned PRINT_LIMIT   = 20;

  // one compressed byte with the idle cycles the sender waits before it
  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } comp_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbd_in_if  comp_if ();
  rbd_out_if decomp_if ();
  rbd_cfg_if cfg_if ();

  rle_byte_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .comp   (comp_if),
    .decomp (decomp_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor state: mirrors the decoder after reset
  // ---------------------------------------------------------------------
  logic [15:0] frame_len_q  = '0;         // configured frame length
  phase_t      dec_phase    = PH_HEADER;  // what the next byte is taken as
  logic [7:0]  run_left_q   = '0;         // repeat count or literals still due
  logic [15:0] owed_q       = '0;         // decompressed bytes still owed
  logic        frame_closed = 1'b1;       // no frame open until a frame_start

  // decoded results waiting for the output side, oldest first
  out_item_t   decoded_q[$];
  // compressed bytes waiting for the driver
  comp_req_t   comp_bytes[$];

  int unsigned mismatches      = 0;
  int unsigned cycles          = 0;
  int unsigned bytes_queued    = 0;
  int unsigned bytes_sent      = 0;
  int unsigned results_seen    = 0;
  int unsigned overruns_seen   = 0;
  int unsigned frame_ends_seen = 0;
  int unsigned settings_used   = 0;

  // idle shaping, changed per phase by the stimulus
  int unsigned in_gap_max    = 3;
  int unsigned out_stall_max = 3;

  // driver and receiver bookkeeping
  comp_req_t   cur_req      = '{item: '0, gap: 0};
  bit          have_req     = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  bit          byte_taken   = 1'b0;  // input transfer seen at the last rising edge
  bit          result_taken = 1'b0;  // output transfer seen at the last rising edge

  function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // hand cnt decompressed bytes to the frame; the frame closes when none are owed
  function automatic void deliver(input logic [7:0] cnt);
    owed_q = owed_q - {8'd0, cnt};
    if (owed_q == 16'd0) begin
      frame_closed = 1'b1;
      dec_phase    = PH_HEADER;
      run_left_q   = '0;
    end
  endfunction

  // advance the predictor by one compressed byte; returns 1 when a result is due
  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    logic [7:0] cnt;
    res           = '0;
    res.out_value = it.in_byte;
    res.status    = STATUS_OK;

    // frame_start restarts everything, this byte is then the first header
    if (it.frame_start) begin
      owed_q       = frame_len_q;
      frame_closed = (frame_len_q == 16'd0);
      dec_phase    = PH_HEADER;
      run_left_q   = '0;
    end

    // closed frame (or none opened yet): byte is dropped, headers too
    if (frame_closed) begin
      res.status = STATUS_OVERRUN;
      return 1'b1;
    end

    case (dec_phase)
      PH_REPEAT: begin
        // repeat count is clamped to what the frame still owes
        cnt = ({8'd0, run_left_q} > owed_q) ? owed_q[7:0] : run_left_q;
        dec_phase  = PH_HEADER;
        run_left_q = '0;
        deliver(cnt);
        res.repeat_count = cnt;
        res.frame_end    = frame_closed;
        return 1'b1;
      end
      PH_LITERAL: begin
        run_left_q = run_left_q - 8'd1;
        if (run_left_q == 8'd0) begin
          dec_phase = PH_HEADER;
        end
        deliver(8'd1);
        res.repeat_count = 8'd1;
        res.frame_end    = frame_closed;
        return 1'b1;
      end
      default: begin
        // header byte read as signed: positive repeats, negative literals
        if (it.in_byte == HDR_NOP) begin
          dec_phase  = PH_HEADER;
          run_left_q = '0;
        end else if (it.in_byte < HDR_LIT_FIRST) begin
          dec_phase  = PH_REPEAT;
          run_left_q = it.in_byte;
        end else begin
          // negation in 8 bits, 0x80 comes out as 128 literals
          dec_phase  = PH_LITERAL;
          run_left_q = 8'd0 - it.in_byte;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[cycle %0d] result %0d: %s got %0d, expected %0d",
               cycles, results_seen, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: compressed bytes change at the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive_comp
    logic go;
    go = 1'b0;
    // the byte on the bus moved at the last rising edge
    if (byte_taken) begin
      have_req   = 1'b0;
      byte_taken = 1'b0;
    end
    if (!rst && !have_req && comp_bytes.size() > 0) begin
      cur_req  = comp_bytes.pop_front();
      have_req = 1'b1;
      gap_left = cur_req.gap;
    end
    // idle the drawn number of cycles, then hold valid until the transfer
    if (!rst && have_req) begin
      if (gap_left == 0) begin
        go = 1'b1;
      end else begin
        gap_left--;
      end
    end
    // one nonblocking write per signal per step, so valid never glitches
    comp_if.valid       <= go;
    comp_if.in_byte     <= cur_req.item.in_byte;
    comp_if.frame_start <= cur_req.item.frame_start;
  end

  // receiver: after each result transfer, stall a drawn number of cycles
  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      stall_left   = $urandom_range(out_stall_max, 0);
    end
    if (rst || stall_left > 0) begin
      if (stall_left > 0) begin
        stall_left--;
      end
      decomp_if.ready <= 1'b0;
    end else begin
      decomp_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: both channels sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    in_item_t  it;
    out_item_t res;
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, decoded_q.size());
      $display("rle_byte_decoder_tb: FAIL");
      $finish;
    end else if (!rst) begin
      // input transfer: predict what this compressed byte produces
      if (comp_if.valid && comp_if.ready) begin
        byte_taken     = 1'b1;
        bytes_sent++;
        it.in_byte     = comp_if.in_byte;
        it.frame_start = comp_if.frame_start;
        if (decode_byte(it, res)) begin
          decoded_q.push_back(res);
        end
      end
      // output transfer: compare with the oldest prediction
      if (decomp_if.valid && decomp_if.ready) begin
        result_taken = 1'b1;
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing expected, out_value",
                          decomp_if.out_value, -1);
        end else begin
          want = decoded_q.pop_front();
          if (want.status == STATUS_OVERRUN) overruns_seen++;
          if (want.frame_end) frame_ends_seen++;
          if (decomp_if.out_value !== want.out_value)
            report_mismatch("out_value", decomp_if.out_value, want.out_value);
          if (decomp_if.repeat_count !== want.repeat_count)
            report_mismatch("repeat_count", decomp_if.repeat_count, want.repeat_count);
          if (decomp_if.frame_end !== want.frame_end)
            report_mismatch("frame_end", decomp_if.frame_end, want.frame_end);
          if (decomp_if.status !== want.status)
            report_mismatch("status", decomp_if.status, want.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic start);
    comp_req_t r;
    r.item.in_byte     = b;
    r.item.frame_start = start;
    r.gap              = $urandom_range(in_gap_max, 0);
    comp_bytes.push_back(r);
    bytes_queued++;
  endtask

  // one frame of runs with random content; a sloppy frame lets runs cross the
  // frame end and trails a few bytes after it, a long frame is cut off at the
  // budget and simply abandoned by the next frame_start
  task automatic push_frame(input bit sloppy, input int unsigned budget);
    int unsigned owed;
    int unsigned n;
    int unsigned cap;
    int unsigned first_byte;
    int unsigned kind;
    logic        start;
    owed       = frame_len_q;
    start      = 1'b1;
    first_byte = bytes_queued;
    if (owed == 0) begin
      // empty frame: the start byte already overruns, so does the rest
      push_byte(8'($urandom), 1'b1);
      repeat ($urandom_range(2, 0)) push_byte(8'($urandom), 1'b0);
      return;
    end
    while (owed > 0 && bytes_queued - first_byte < budget) begin
      kind = $urandom_range(9, 0);
      if (kind == 0) begin
        push_byte(HDR_NOP, start);
      end else begin
        cap = (kind < 5) ? 127 : 128;
        if (!sloppy) cap = min_u(cap, owed);
        // mostly short runs, now and then anything up to the cap
        n = ($urandom_range(7, 0) == 0) ? $urandom_range(cap, 1)
                                        : $urandom_range(min_u(cap, 8), 1);
        if (kind < 5) begin
          push_byte(8'(n), start);
          push_byte(8'($urandom), 1'b0);
        end else begin
          push_byte(8'(256 - n), start);
          repeat (n) push_byte(8'($urandom), 1'b0);
        end
        owed = owed - min_u(n, owed);
      end
      start = 1'b0;
    end
    if (sloppy) begin
      repeat ($urandom_range(3, 0)) push_byte(8'($urandom), 1'b0);
    end
  endtask

  // sender pause: everything sent, every prediction compared, pipeline quiet
  task automatic wait_idle();
    while (comp_bytes.size() > 0 || have_req || decoded_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_length(input logic [15:0] len);
    @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.frame_length <= len;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    frame_len_q = len;
    settings_used++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] lengths [8];
    logic [7:0]  lit_bytes [9];
    int unsigned phase_first;

    comp_if.valid       = 1'b0;
    comp_if.in_byte     = '0;
    comp_if.frame_start = 1'b0;
    decomp_if.ready     = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.frame_length = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // no frame opened yet: every byte overruns, header values included
    push_byte(HDR_NOP, 1'b0);
    push_byte(HDR_LIT_FIRST, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    // frame_length is still 0 from reset: the frame closes on its start byte
    push_byte(8'h01, 1'b1);
    wait_idle();

    write_frame_length(16'd10);
    // repeat run of 3, then a header that does nothing
    push_byte(8'h03, 1'b1);
    push_byte(8'hAA, 1'b0);
    push_byte(HDR_NOP, 1'b0);
    // 0x80 opens 128 literals; 7 fit the frame, the last two overrun
    push_byte(HDR_LIT_FIRST, 1'b0);
    lit_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h3C};
    foreach (lit_bytes[i]) push_byte(lit_bytes[i], 1'b0);
    // longest repeat run clamped to the whole frame
    push_byte(8'h7F, 1'b1);
    push_byte(8'h55, 1'b0);
    // single literal of 0xFF
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    // frame_start in the middle of a repeat run restarts the decoder
    push_byte(8'h05, 1'b1);
    push_byte(8'h02, 1'b1);
    push_byte(8'h33, 1'b0);

    // --- random part, one phase per frame_length setting ---
    lengths = '{16'd1, 16'd65535, 16'd0, 16'd37, 16'd300,
                16'($urandom_range(2000, 2)), 16'd129, 16'd6};
    foreach (lengths[i]) begin
      wait_idle();
      // some phases run with no idle cycles on one side or the other
      in_gap_max    = (i % 3 == 1) ? 0 : 3;
      out_stall_max = (i % 4 == 2) ? 0 : 3;
      write_frame_length(lengths[i]);
      phase_first = bytes_queued;
      while (bytes_queued - phase_first < PHASE_BYTES) begin
        case ($urandom_range(11, 0))
          0: begin
            // noise: random bytes with stray frame starts
            repeat ($urandom_range(6, 1)) begin
              push_byte(8'($urandom), ($urandom_range(7, 0) == 0));
            end
          end
          1: push_frame(1'b1, FRAME_BUDGET);
          2: wait_idle();
          default: push_frame(1'b0, FRAME_BUDGET);
        endcase
      end
    end
    wait_idle();

    $display("covered: %0d compressed bytes, %0d results (%0d overruns, %0d frame ends)",
             bytes_sent, results_seen, overruns_seen, frame_ends_seen);
    $display("covered: %0d frame_length settings from 0 to 65535, %0d mismatches",
             settings_used, mismatches);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("rle_byte_decoder_tb: PASS");
    end else begin
      $display("rle_byte_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== rle_byte_decoder.f =====
design/rbd_pkg.sv
design/rbd_if.sv
design/rbd_in_stage.sv
design/rbd_decode.sv
design/rbd_out_stage.sv
design/rle_byte_decoder.sv
dv/rle_byte_decoder_tb.sv
